/* sv/vrrb_pkg.sv */
package vrrb_pkg;

  localparam int unsigned StoreBytes  = 4096;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned MaxRecords  = 256;

  localparam int unsigned AddrW  = $clog2(StoreBytes);     // 12
  localparam int unsigned SizeW  = AddrW + 1;              // 13
  localparam int unsigned SlotW  = $clog2(MaxRecords);     // 8
  localparam int unsigned CountW = SlotW + 1;              // 9

  typedef enum logic [2:0] {
    OP_ADD_BEGIN = 3'd0,
    OP_ADD_DATA  = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_PEEK_HEAD = 3'd3,
    OP_PEEK_TAIL = 3'd4,
    OP_PEEK_NEXT = 3'd5,
    OP_PEEK_PREV = 3'd6,
    OP_FETCH     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERSIZE = 2'd2,
    ST_SEQ      = 2'd3
  } status_e;

  // Command handed from the front end to the execution engine.
  typedef struct packed {
    op_e          op;
    logic [11:0]  record_length;
    logic [7:0]   data_byte;
    logic         last_byte;
    logic [11:0]  byte_offset;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  evicted_count;
    logic        evicted_msb;
    logic [7:0]  fetched_byte;
    logic [11:0] reported_length;
    status_e     status;
  } rsp_t;

endpackage

/* sv/variable_record_ring_buffer_core.sv */
// Add_data and status-only answers go straight from the idle state to the output state; fetch
// passes S_RDB, peek and remove pass S_RDREP and S_REP, and add_begin passes S_RDH and S_FIT,
// rereading head and tail per evicted record (one slot-table read per fit check).
// One transaction at a time in the engine; a held result stalls the engine.
// Reset: asynchronous active low; clears control state and capacity (4096).
// Byte store and slot tables hold no reset value.
module variable_record_ring_buffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // operation, record_length, data_byte, byte_offset
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // status, reported_length, fetched_byte, evicted_count
);

  logic [12:0] cap_q;
  vrrb_pkg::cmd_t in_cmd, q_cmd;
  vrrb_pkg::rsp_t rsp;
  logic q_valid, q_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 13'd4096;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_comb begin
    in_cmd.op            = vrrb_pkg::op_e'(s_axis_tdata_i[2:0]);
    in_cmd.record_length = s_axis_tdata_i[14:3];
    in_cmd.data_byte     = s_axis_tdata_i[22:15];
    in_cmd.byte_offset   = s_axis_tdata_i[34:23];
    in_cmd.last_byte     = s_axis_tlast_i;
  end

  vrrb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (in_cmd),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_cmd_o    (q_cmd)
  );

  vrrb_engine u_engine (
    .clk_i, .rst_ni,
    .cap_i       (cap_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_cmd_i     (q_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_rsp_o   (rsp)
  );

  assign m_axis_tdata_o = {1'b0, rsp.evicted_msb, rsp.evicted_count, rsp.fetched_byte,
                           rsp.reported_length, rsp.status};

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[31])
    else $error("pad bit set");
`endif

endmodule

/* sv/vrrb_front.sv */
module vrrb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vrrb_pkg::cmd_t in_cmd_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output vrrb_pkg::cmd_t q_cmd_o
);

  // Two-entry command queue between the slave port and the engine.
  vrrb_pkg::cmd_t mem_q [2];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_cmd_i;
    end
  end

endmodule

/* sv/vrrb_engine.sv */
module vrrb_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [12:0]    cap_i,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  vrrb_pkg::cmd_t q_cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vrrb_pkg::rsp_t out_rsp_o
);

  localparam int unsigned AW = vrrb_pkg::AddrW;
  localparam int unsigned SW = vrrb_pkg::SizeW;
  localparam int unsigned LW = vrrb_pkg::SlotW;
  localparam int unsigned CW = vrrb_pkg::CountW;
  localparam logic [SW-1:0] Hdr = SW'(vrrb_pkg::HeaderBytes);
  localparam logic [SW-1:0] StoreSz = SW'(vrrb_pkg::StoreBytes);
  localparam logic [CW-1:0] MaxRec = CW'(vrrb_pkg::MaxRecords);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDH   = 7'b0000010,   // read head and tail start
    S_FIT   = 7'b0000100,   // evaluate fit, maybe evict
    S_RDREP = 7'b0001000,   // read slot tables for report
    S_REP   = 7'b0010000,
    S_RDB   = 7'b0100000,   // byte read for fetch
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // slot tables and byte store
  logic [AW-1:0] start_mem [vrrb_pkg::MaxRecords];
  logic [SW-1:0] size_mem  [vrrb_pkg::MaxRecords];
  logic [7:0]    byte_mem  [vrrb_pkg::StoreBytes];

  logic [LW-1:0] oldest_q, oldest_d, cursor_q, cursor_d;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] newest_q, newest_d, wofs_q, wofs_d;
  logic [AW-1:0] rstart_q, rstart_d;
  logic [11:0]   rlen_q, rlen_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pstart_q, pstart_d;
  logic [11:0]   plen_q, plen_d, pleft_q, pleft_d;
  logic [8:0]    evict_q, evict_d;
  vrrb_pkg::cmd_t cmd_q, cmd_d;
  vrrb_pkg::rsp_t rsp_q, rsp_d;

  // memory ports
  logic          st_we;
  logic [LW-1:0] st_wa;
  logic [AW-1:0] st_wd_start;
  logic [SW-1:0] st_wd_size;
  logic [LW-1:0] ra0, ra1;
  logic [AW-1:0] rd_start0_q, rd_start1_q;
  logic [SW-1:0] rd_size0_q;
  logic          bw_we;
  logic [AW-1:0] bw_a, br_a;
  logic [7:0]    br_q;

  // byte writes happen only while the add_data transaction is taken in
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      start_mem[st_wa] <= st_wd_start;
      size_mem[st_wa]  <= st_wd_size;
    end
    rd_start0_q <= start_mem[ra0];
    rd_size0_q  <= size_mem[ra0];
    rd_start1_q <= start_mem[ra1];
    if (bw_we) begin
      byte_mem[bw_a] <= q_cmd_i.data_byte;
    end
    br_q <= byte_mem[br_a];
  end

  logic [SW-1:0] cap, sz, free_end, newest_sum;
  logic [LW-1:0] tail_slot, last_k, k_cur, k_new;
  logic          fits;
  logic [AW-1:0] fit_at;
  logic [12:0]   fetch_sum;

  always_comb begin
    cap = (cap_i > StoreSz) ? StoreSz : cap_i;
    sz  = {1'b0, cmd_q.record_length} + Hdr;
    tail_slot = oldest_q + LW'(count_q - CW'(1));
    last_k = LW'(count_q - CW'(1));
    k_cur = cursor_q - oldest_q;
    if ({1'b0, k_cur} >= count_q) begin
      k_cur = '0;
    end
    case (cmd_q.op)
      vrrb_pkg::OP_PEEK_HEAD: k_new = '0;
      vrrb_pkg::OP_PEEK_TAIL: k_new = last_k;
      vrrb_pkg::OP_PEEK_NEXT: k_new = (k_cur == last_k) ? '0 : k_cur + LW'(1);
      vrrb_pkg::OP_PEEK_PREV: k_new = (k_cur == '0) ? last_k : k_cur - LW'(1);
      default:                k_new = '0;
    endcase
    // fit check uses head (rd_start0_q) and tail (rd_start1_q)
    fits   = 1'b0;
    fit_at = '0;
    free_end = cap - newest_q;
    if (count_q == '0) begin
      fits = 1'b1;
    end else if (count_q >= MaxRec) begin
      fits = 1'b0;
    end else if (rd_start0_q <= rd_start1_q) begin
      if (newest_q <= cap && free_end >= sz) begin
        fits = 1'b1; fit_at = AW'(newest_q);
      end else if ({1'b0, rd_start0_q} >= sz) begin
        fits = 1'b1;
      end
    end else if (newest_q <= {1'b0, rd_start0_q} &&
                 ({1'b0, rd_start0_q} - newest_q) >= sz) begin
      fits = 1'b1; fit_at = AW'(newest_q);
    end
    newest_sum = {1'b0, pstart_q} + {1'b0, plen_q} + Hdr;
    fetch_sum = {1'b0, rstart_q} + 13'(Hdr) + {1'b0, cmd_q.byte_offset};
  end

  assign q_ready_o   = (state_q == S_IDLE) && !(out_valid_o && !out_ready_i);
  assign out_rsp_o   = rsp_q;
  logic outv_q, outv_d;
  assign out_valid_o = outv_q;

  always_comb begin
    state_d = state_q;
    oldest_d = oldest_q; cursor_d = cursor_q; count_d = count_q;
    newest_d = newest_q; wofs_d = wofs_q; rstart_d = rstart_q; rlen_d = rlen_q;
    pend_d = pend_q; pstart_d = pstart_q; plen_d = plen_q; pleft_d = pleft_q;
    evict_d = evict_q; cmd_d = cmd_q; rsp_d = rsp_q;
    outv_d = outv_q && !out_ready_i;
    st_we = 1'b0; st_wa = oldest_q + LW'(count_q);
    st_wd_start = pstart_q; st_wd_size = {1'b0, plen_q} + Hdr;
    ra0 = oldest_q; ra1 = tail_slot;
    bw_we = 1'b0; bw_a = AW'(wofs_q);
    br_a = AW'(fetch_sum);
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && q_ready_o) begin
          cmd_d = q_cmd_i;
          evict_d = '0;
          rsp_d = '0;
          case (q_cmd_i.op)
            vrrb_pkg::OP_ADD_BEGIN: begin
              if (pend_q) begin
                rsp_d.status = vrrb_pkg::ST_SEQ; state_d = S_OUT;
              end else if ({1'b0, q_cmd_i.record_length} + Hdr > cap) begin
                rsp_d.status = vrrb_pkg::ST_OVERSIZE; state_d = S_OUT;
              end else begin
                state_d = S_RDH;
              end
            end
            vrrb_pkg::OP_ADD_DATA: begin
              if (!pend_q) rsp_d.status = vrrb_pkg::ST_SEQ;
              state_d = S_OUT;
              if (pend_q) begin
                bw_we = 1'b1;
                wofs_d = wofs_q + SW'(1);
                pleft_d = pleft_q - 12'd1;
                if (pleft_d == '0 || q_cmd_i.last_byte) begin
                  if ((pleft_d == '0) != q_cmd_i.last_byte) rsp_d.status = vrrb_pkg::ST_SEQ;
                  st_we = 1'b1;
                  count_d = count_q + CW'(1);
                  newest_d = newest_sum;
                  pend_d = 1'b0;
                  pleft_d = '0;
                end
              end
            end
            vrrb_pkg::OP_FETCH: begin
              if (q_cmd_i.byte_offset >= rlen_q) begin
                rsp_d.status = vrrb_pkg::ST_SEQ; state_d = S_OUT;
              end else begin
                br_a = AW'({1'b0, rstart_q} + 13'(Hdr) + {1'b0, q_cmd_i.byte_offset});
                state_d = S_RDB;
              end
            end
            default: begin
              if (count_q == '0) begin
                cursor_d = oldest_q;
                rsp_d.status = vrrb_pkg::ST_EMPTY;
                state_d = S_OUT;
              end else begin
                state_d = S_RDREP;
              end
            end
          endcase
        end
      end
      S_RDH: state_d = S_FIT;
      S_FIT: begin
        if (fits) begin
          pstart_d = fit_at; plen_d = cmd_q.record_length;
          pleft_d = cmd_q.record_length;
          wofs_d = {1'b0, fit_at} + Hdr;
          pend_d = 1'b1;
          if (cmd_q.record_length == '0) begin
            st_we = 1'b1; st_wd_start = fit_at; st_wd_size = Hdr;
            count_d = count_q + CW'(1);
            newest_d = {1'b0, fit_at} + Hdr;
            pend_d = 1'b0; pleft_d = '0;
          end
          rsp_d.evicted_count = evict_q[7:0];
          rsp_d.evicted_msb = evict_q[8];
          state_d = S_OUT;
        end else if (count_q == '0) begin
          rsp_d.status = vrrb_pkg::ST_OVERSIZE;
          rsp_d.evicted_count = evict_q[7:0];
          rsp_d.evicted_msb = evict_q[8];
          state_d = S_OUT;
        end else begin
          // pop oldest, then reread head and tail
          if (cursor_q == oldest_q) cursor_d = oldest_q + LW'(1);
          oldest_d = oldest_q + LW'(1);
          count_d = count_q - CW'(1);
          if (count_d == '0) begin
            cursor_d = oldest_d; newest_d = '0;
          end
          evict_d = evict_q + 9'd1;
          state_d = S_RDH;
        end
      end
      S_RDREP: begin
        if (cmd_q.op == vrrb_pkg::OP_REMOVE) begin
          ra0 = oldest_q;
          if (cursor_q == oldest_q) cursor_d = oldest_q + LW'(1);
          oldest_d = oldest_q + LW'(1);
          count_d = count_q - CW'(1);
          if (count_d == '0) begin
            cursor_d = oldest_d; newest_d = '0;
          end
        end else begin
          ra0 = oldest_q + k_new;
          cursor_d = oldest_q + k_new;
        end
        state_d = S_REP;
      end
      S_REP: begin
        rstart_d = rd_start0_q;
        rlen_d = (rd_size0_q >= Hdr) ? 12'(rd_size0_q - Hdr) : '0;
        rsp_d.reported_length = rlen_d;
        state_d = S_OUT;
      end
      S_RDB: begin
        rsp_d.fetched_byte = br_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!outv_q || out_ready_i) begin
          outv_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oldest_q <= '0; cursor_q <= '0; count_q <= '0;
      newest_q <= '0; wofs_q <= '0; rstart_q <= '0; rlen_q <= '0;
      pend_q <= 1'b0; pstart_q <= '0; plen_q <= '0; pleft_q <= '0;
      evict_q <= '0; outv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      oldest_q <= oldest_d; cursor_q <= cursor_d; count_q <= count_d;
      newest_q <= newest_d; wofs_q <= wofs_d; rstart_q <= rstart_d; rlen_q <= rlen_d;
      pend_q <= pend_d; pstart_q <= pstart_d; plen_q <= plen_d; pleft_q <= pleft_d;
      evict_q <= evict_d; outv_q <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rsp_q <= rsp_d;
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Hdr = 16;
  localparam int unsigned Slots = 256;
  localparam int unsigned Bytes = 4096;

  typedef struct {
    vrrb_pkg::op_e op;
    logic [11:0]   rlen;
    logic [7:0]    data;
    logic          last;
    logic [11:0]   offs;
  } tb_cmd_t;

  class ring_scoreboard;
    logic [31:0] pending_rsp[$];
    int errors = 0;
    int seen = 0;

    function void note(logic [31:0] rsp);
      pending_rsp.push_back(rsp);
    endfunction

    function void check(logic [31:0] act);
      logic [31:0] exp;
      seen++;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response %h", $time, act);
        return;
      end
      exp = pending_rsp.pop_front();
      if (exp[1:0] != act[1:0]) begin
        errors++;
        $display("%0t: status exp %0d act %0d", $time, exp[1:0], act[1:0]);
      end
      if (exp[13:2] != act[13:2]) begin
        errors++;
        $display("%0t: length exp %0d act %0d", $time, exp[13:2], act[13:2]);
      end
      if (exp[21:14] != act[21:14]) begin
        errors++;
        $display("%0t: fetched byte exp %h act %h", $time, exp[21:14], act[21:14]);
      end
      if (exp[30:22] != act[30:22]) begin
        errors++;
        $display("%0t: evicted exp %0d act %0d", $time, exp[30:22], act[30:22]);
      end
      if (act[31] !== 1'b0) begin
        errors++;
        $display("%0t: pad bit exp 0 act %b", $time, act[31]);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [12:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;   // operation, record_length, data_byte, byte_offset
  logic        s_axis_tlast_i = 1'b0; // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // status, reported_length, fetched_byte, evicted_count

  variable_record_ring_buffer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  ring_scoreboard sb = new();
  bit idle_on = 1'b1;
  int sent = 0;
  int op_hits[8];
  int evict_hits = 0;

  // predictor state
  logic [7:0] mem[Bytes];
  bit         mem_wr[Bytes];
  int unsigned rec_start[Slots];
  int unsigned rec_size[Slots];
  int unsigned oldest, rec_cnt, cursor, newest_end, wr_ofs, rep_start, rep_len;
  int unsigned pend_start, pend_len, pend_left, cap_reg;
  bit          adding;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned cap_eff();
    return cap_reg > Bytes ? Bytes : cap_reg;
  endfunction

  function automatic bit room_for(int unsigned sz, output int unsigned at);
    int unsigned head, tail;
    at = 0;
    if (rec_cnt == 0) return sz <= cap_eff();
    if (rec_cnt >= Slots) return 0;
    head = rec_start[oldest];
    tail = rec_start[(oldest + rec_cnt - 1) % Slots];
    if (head <= tail) begin
      if (newest_end <= cap_eff() && cap_eff() - newest_end >= sz) begin
        at = newest_end;
        return 1;
      end
      if (head >= sz) return 1;
    end else if (newest_end <= head && head - newest_end >= sz) begin
      at = newest_end;
      return 1;
    end
    return 0;
  endfunction

  function automatic int unsigned drop_oldest();
    int unsigned s = oldest;
    int unsigned nxt = (s + 1) % Slots;
    if (cursor == s) cursor = nxt;
    oldest = nxt;
    rec_cnt--;
    if (rec_cnt == 0) begin
      cursor = oldest;
      newest_end = 0;
    end
    return s;
  endfunction

  function automatic void commit_record();
    int unsigned s = (oldest + rec_cnt) % Slots;
    rec_start[s] = pend_start;
    rec_size[s] = pend_len + Hdr;
    rec_cnt++;
    newest_end = pend_start + pend_len + Hdr;
    adding = 0;
    pend_left = 0;
  endfunction

  function automatic int unsigned report_slot(int unsigned s);
    rep_start = rec_start[s];
    rep_len = rec_size[s] >= Hdr ? rec_size[s] - Hdr : 0;
    return rep_len;
  endfunction

  function automatic logic [31:0] ring_response(tb_cmd_t c);
    int unsigned st = vrrb_pkg::ST_OK, len = 0, fb = 0, ev = 0, sz, at, k;
    case (c.op)
      vrrb_pkg::OP_ADD_BEGIN: begin
        sz = c.rlen + Hdr;
        if (adding) st = vrrb_pkg::ST_SEQ;
        else if (sz > cap_eff()) st = vrrb_pkg::ST_OVERSIZE;
        else begin
          while (!room_for(sz, at)) begin
            if (rec_cnt == 0) begin
              st = vrrb_pkg::ST_OVERSIZE;
              break;
            end
            void'(drop_oldest());
            ev++;
          end
          if (st == vrrb_pkg::ST_OK) begin
            pend_start = at;
            pend_len = c.rlen;
            pend_left = c.rlen;
            wr_ofs = at + Hdr;
            adding = 1;
            if (c.rlen == 0) commit_record();
          end
        end
      end
      vrrb_pkg::OP_ADD_DATA: begin
        if (!adding) st = vrrb_pkg::ST_SEQ;
        else begin
          mem[wr_ofs % Bytes] = c.data;
          mem_wr[wr_ofs % Bytes] = 1;
          wr_ofs = (wr_ofs + 1) & 13'h1fff;
          pend_left--;
          if (pend_left == 0 || c.last) begin
            if ((pend_left == 0) != c.last) st = vrrb_pkg::ST_SEQ;
            commit_record();
          end
        end
      end
      vrrb_pkg::OP_FETCH: begin
        if (c.offs >= rep_len) st = vrrb_pkg::ST_SEQ;
        else fb = mem[(rep_start + Hdr + c.offs) % Bytes];
      end
      default: begin
        if (rec_cnt == 0) begin
          cursor = oldest;
          st = vrrb_pkg::ST_EMPTY;
        end else if (c.op == vrrb_pkg::OP_REMOVE) begin
          len = report_slot(drop_oldest());
        end else begin
          k = (cursor + Slots - oldest) % Slots;
          if (k >= rec_cnt) k = 0;
          case (c.op)
            vrrb_pkg::OP_PEEK_HEAD: k = 0;
            vrrb_pkg::OP_PEEK_TAIL: k = rec_cnt - 1;
            vrrb_pkg::OP_PEEK_NEXT: k = (k + 1) % rec_cnt;
            default:                k = (k + rec_cnt - 1) % rec_cnt;
          endcase
          cursor = (oldest + k) % Slots;
          len = report_slot(cursor);
        end
      end
    endcase
    if (ev != 0) evict_hits++;
    return {1'b0, ev[8:0], fb[7:0], len[11:0], st[1:0]};
  endfunction

  task automatic send(tb_cmd_t c);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {5'b0, c.offs, c.data, c.rlen, c.op};
    s_axis_tlast_i <= c.last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note(ring_response(c));
    op_hits[c.op]++;
    sent++;
  endtask

  task automatic set_capacity(logic [12:0] val);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic tb_cmd_t make(vrrb_pkg::op_e op, int unsigned rlen, bit last = 0,
                                   int unsigned offs = 0);
    tb_cmd_t c;
    c.op = op;
    c.rlen = rlen;
    c.data = $urandom_range(0, 255);
    c.last = last;
    c.offs = offs;
    return c;
  endfunction

  // fetch whose target byte was written (or lies outside the record), else a harmless peek
  function automatic tb_cmd_t pick_fetch();
    tb_cmd_t c = make(vrrb_pkg::OP_FETCH, $urandom_range(0, 4095), $urandom_range(0, 1),
                      $urandom_range(0, 4095));
    if (rep_len != 0 && $urandom_range(0, 4) != 0)
      c.offs = $urandom_range(0, rep_len - 1);
    if (c.offs < rep_len && !mem_wr[(rep_start + Hdr + c.offs) % Bytes])
      c.op = vrrb_pkg::OP_PEEK_HEAD;
    return c;
  endfunction

  function automatic tb_cmd_t random_cmd();
    tb_cmd_t c;
    int unsigned r = $urandom_range(0, 99);
    int unsigned len;
    c = make(vrrb_pkg::op_e'($urandom_range(2, 6)), $urandom_range(0, 4095),
             $urandom_range(0, 1), $urandom_range(0, 4095));
    if (adding) begin
      if (r < 92) begin
        c.op = vrrb_pkg::OP_ADD_DATA;
        c.last = (pend_left == 1);
      end else if (r < 96) begin
        c.op = vrrb_pkg::OP_ADD_DATA;
      end else if (r < 98) begin
        c.op = vrrb_pkg::OP_ADD_BEGIN;
      end
    end else begin
      if (r < 45) begin
        c.op = vrrb_pkg::OP_ADD_BEGIN;
        len = $urandom_range(0, 99);
        if (len < 70) c.rlen = $urandom_range(0, 30);
        else if (len < 95) c.rlen = $urandom_range(31, 300);
      end else if (r < 55) c.op = vrrb_pkg::OP_REMOVE;
      else if (r < 70) c = pick_fetch();
      else if (r < 74) c.op = vrrb_pkg::OP_ADD_DATA;
    end
    return c;
  endfunction

  task automatic run_random(int n);
    repeat (n) send(random_cmd());
  endtask

  initial begin
    cap_reg = 4096;
    foreach (mem_wr[i]) mem_wr[i] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty store, sequence errors, zero-length and oversized adds
    send(make(vrrb_pkg::OP_REMOVE, 0));
    send(make(vrrb_pkg::OP_PEEK_HEAD, 0));
    send(make(vrrb_pkg::OP_PEEK_TAIL, 0));
    send(make(vrrb_pkg::OP_PEEK_NEXT, 0));
    send(make(vrrb_pkg::OP_PEEK_PREV, 0));
    send(make(vrrb_pkg::OP_FETCH, 0, 0, 0));
    send(make(vrrb_pkg::OP_ADD_DATA, 0, 1));
    send(make(vrrb_pkg::OP_ADD_BEGIN, 0));
    send(make(vrrb_pkg::OP_ADD_BEGIN, 4095));
    send(make(vrrb_pkg::OP_ADD_BEGIN, 3));
    send(make(vrrb_pkg::OP_ADD_BEGIN, 5));
    send(make(vrrb_pkg::OP_ADD_DATA, 0, 1));    // early last: commit with declared length
    send(make(vrrb_pkg::OP_ADD_BEGIN, 2));
    send(make(vrrb_pkg::OP_ADD_DATA, 0, 0));
    send(make(vrrb_pkg::OP_ADD_DATA, 0, 0));    // length reached without last
    send(make(vrrb_pkg::OP_PEEK_TAIL, 0));
    send(make(vrrb_pkg::OP_FETCH, 0, 0, 1));
    send(make(vrrb_pkg::OP_FETCH, 0, 0, 2));
    send(make(vrrb_pkg::OP_PEEK_NEXT, 0));
    send(make(vrrb_pkg::OP_PEEK_PREV, 0));
    send(make(vrrb_pkg::OP_ADD_BEGIN, 4080));
    send(make(vrrb_pkg::OP_REMOVE, 0));
    send(make(vrrb_pkg::OP_REMOVE, 0));

    set_capacity(13'd32);
    send(make(vrrb_pkg::OP_ADD_BEGIN, 17));
    send(make(vrrb_pkg::OP_ADD_BEGIN, 16));
    run_random(150);

    // full slot ring: zero-length records past 256
    set_capacity(13'h1fff);
    while (adding) send(make(vrrb_pkg::OP_ADD_DATA, 0, 1));
    repeat (270) send(make(vrrb_pkg::OP_ADD_BEGIN, 0));
    send(make(vrrb_pkg::OP_ADD_BEGIN, 4080));
    run_random(80);

    set_capacity(13'd300);
    run_random(350);

    set_capacity(13'd4096);
    run_random(350);
    idle_on = 0;
    run_random(200);

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("%0d commands (add_begin %0d, add_data %0d, fetch %0d), %0d adds evicted,",
             sent, op_hits[vrrb_pkg::OP_ADD_BEGIN], op_hits[vrrb_pkg::OP_ADD_DATA],
             op_hits[vrrb_pkg::OP_FETCH], evict_hits);
    $display("capacities 4096, 32, 8191, 300; %0d responses checked", sb.seen);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // response side: random stall bursts while idling is enabled
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check(m_axis_tdata_o);
  end

  initial begin
    #50ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
